// ===== design/mandel_pkg.sv =====
// shared types and constants of the mandelbrot escape-time pixel core
`default_nettype none

package mandel_pkg;

	localparam int FRAC_BITS      = 28;
	localparam int PALETTE_SIZE   = 16;
	localparam int MAX_RESOLUTION = 4096;

	localparam int COORD_W = $clog2(MAX_RESOLUTION);
	localparam int PAL_W   = $clog2(PALETTE_SIZE);
	localparam int COORD_REG_W = 32;
	localparam int STEP_W  = 31;
	localparam int ITER_W  = 16;
	localparam int OFFS_W  = 8;
	localparam int DATA_W  = 32;
	localparam int PADDR_W = 5;

	// point c: view origin plus pixel index times step
	localparam int C_W   = COORD_W + STEP_W + 2;
	// sum of squares difference plus c
	localparam int N_W   = C_W + 1;
	// iterate kept while |z| < 2
	localparam int Z_W   = FRAC_BITS + 2;
	localparam int P_W   = 2 * Z_W;
	// rounded square, below 4
	localparam int SQ_W  = FRAC_BITS + 2;
	localparam int SUM_W = SQ_W + 1;
	// rounded 2*zr*zi, magnitude up to 2^(FRAC_BITS+3)
	localparam int PZ_W  = FRAC_BITS + 4;

	typedef struct packed {
		logic signed [COORD_REG_W-1:0] view_left;
		logic signed [COORD_REG_W-1:0] view_top;
		logic [STEP_W-1:0]             x_step;
		logic [STEP_W-1:0]             y_step;
		logic [ITER_W-1:0]             iteration_limit;
		logic [OFFS_W-1:0]             palette_offset;
	} cfg_t;

	typedef enum logic [2:0] {
		REG_VIEW_LEFT       = 3'd0,
		REG_VIEW_TOP        = 3'd1,
		REG_X_STEP          = 3'd2,
		REG_Y_STEP          = 3'd3,
		REG_ITERATION_LIMIT = 3'd4,
		REG_PALETTE_OFFSET  = 3'd5
	} reg_idx_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOAD,
		S_ITER,
		S_SQUARE,
		S_DONE
	} state_t;

	typedef struct packed {
		logic capture;
		logic load;
		logic step;
		logic square;
	} dp_cmd_t;

	typedef struct packed {
		logic stop;
		logic mag_esc;
	} dp_stat_t;

endpackage

`default_nettype wire

// ===== design/mandel_regs.sv =====
// configuration register file behind the apb-style port
`default_nettype none

module mandel_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [mandel_pkg::PADDR_W-1:0] paddr,
	input  wire logic [mandel_pkg::DATA_W-1:0]  pwdata,
	output logic [mandel_pkg::DATA_W-1:0]       prdata,
	output logic                               pready,
	output mandel_pkg::cfg_t                   cfg
);

	mandel_pkg::cfg_t     cfg_q;
	mandel_pkg::reg_idx_t idx;
	logic                 wr_en;

	assign pready = 1'b1;
	assign idx    = mandel_pkg::reg_idx_t'(paddr[mandel_pkg::PADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.view_left       <= 32'shE0000000;
			cfg_q.view_top        <= 32'sh10000000;
			cfg_q.x_step          <= 31'd262144;
			cfg_q.y_step          <= 31'd262144;
			cfg_q.iteration_limit <= 16'd256;
			cfg_q.palette_offset  <= 8'd0;
		end else if (wr_en) begin
			unique case (idx)
				mandel_pkg::REG_VIEW_LEFT: begin
					cfg_q.view_left <= pwdata;
				end
				mandel_pkg::REG_VIEW_TOP: begin
					cfg_q.view_top <= pwdata;
				end
				mandel_pkg::REG_X_STEP: begin
					cfg_q.x_step <= pwdata[mandel_pkg::STEP_W-1:0];
				end
				mandel_pkg::REG_Y_STEP: begin
					cfg_q.y_step <= pwdata[mandel_pkg::STEP_W-1:0];
				end
				mandel_pkg::REG_ITERATION_LIMIT: begin
					cfg_q.iteration_limit <= pwdata[mandel_pkg::ITER_W-1:0];
				end
				mandel_pkg::REG_PALETTE_OFFSET: begin
					cfg_q.palette_offset <= pwdata[mandel_pkg::OFFS_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			mandel_pkg::REG_VIEW_LEFT:       prdata = cfg_q.view_left;
			mandel_pkg::REG_VIEW_TOP:        prdata = cfg_q.view_top;
			mandel_pkg::REG_X_STEP:          prdata = mandel_pkg::DATA_W'(cfg_q.x_step);
			mandel_pkg::REG_Y_STEP:          prdata = mandel_pkg::DATA_W'(cfg_q.y_step);
			mandel_pkg::REG_ITERATION_LIMIT: prdata = mandel_pkg::DATA_W'(cfg_q.iteration_limit);
			mandel_pkg::REG_PALETTE_OFFSET:  prdata = mandel_pkg::DATA_W'(cfg_q.palette_offset);
			default:                         prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// ===== design/mandel_ctrl.sv =====
// controller state machine sequencing load, iterate and square phases
`default_nettype none

module mandel_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	input  wire logic                 out_free,
	input  wire mandel_pkg::dp_stat_t stat,
	output logic                      in_stall,
	output logic                      emit,
	output mandel_pkg::dp_cmd_t       cmd
);

	mandel_pkg::state_t state_q;
	mandel_pkg::state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mandel_pkg::S_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			mandel_pkg::S_IDLE: begin
				if (in_valid) state_next = mandel_pkg::S_LOAD;
			end
			mandel_pkg::S_LOAD: begin
				state_next = mandel_pkg::S_ITER;
			end
			mandel_pkg::S_ITER: begin
				// stop covers the previous sum test and the count limit
				if (stat.stop || stat.mag_esc) begin
					state_next = mandel_pkg::S_DONE;
				end else begin
					state_next = mandel_pkg::S_SQUARE;
				end
			end
			mandel_pkg::S_SQUARE: begin
				state_next = mandel_pkg::S_ITER;
			end
			mandel_pkg::S_DONE: begin
				if (out_free) state_next = mandel_pkg::S_IDLE;
			end
			default: begin
				state_next = mandel_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		in_stall    = 1'b1;
		emit        = 1'b0;
		cmd         = '0;
		unique case (state_q)
			mandel_pkg::S_IDLE: begin
				in_stall    = 1'b0;
				cmd.capture = in_valid;
			end
			mandel_pkg::S_LOAD: begin
				cmd.load = 1'b1;
			end
			mandel_pkg::S_ITER: begin
				cmd.step = !stat.stop;
			end
			mandel_pkg::S_SQUARE: begin
				cmd.square = 1'b1;
			end
			mandel_pkg::S_DONE: begin
				emit = out_free;
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== design/mandel_dp.sv =====
// datapath: point setup, iterate update, three squaring multipliers, count
`default_nettype none

module mandel_dp (
	input  wire logic                               clk,
	input  wire mandel_pkg::cfg_t                   cfg,
	input  wire mandel_pkg::dp_cmd_t                cmd,
	input  wire logic [mandel_pkg::COORD_W-1:0]      row,
	input  wire logic [mandel_pkg::COORD_W-1:0]      column,
	output mandel_pkg::dp_stat_t                    stat,
	output logic                                    res_in_set,
	output logic [mandel_pkg::PAL_W-1:0]            res_palette,
	output logic [mandel_pkg::ITER_W-1:0]           res_iterations
);

	localparam int N_W  = mandel_pkg::N_W;
	localparam int C_W  = mandel_pkg::C_W;
	localparam int Z_W  = mandel_pkg::Z_W;
	localparam int P_W  = mandel_pkg::P_W;
	localparam int SQ_W = mandel_pkg::SQ_W;
	localparam int SUM_W = mandel_pkg::SUM_W;
	localparam int PZ_W = mandel_pkg::PZ_W;
	localparam int FB   = mandel_pkg::FRAC_BITS;
	localparam int PROD_W = mandel_pkg::COORD_W + mandel_pkg::STEP_W;
	localparam int CNT_W  = mandel_pkg::ITER_W + 1;

	localparam logic signed [N_W-1:0] MAG_LIM = N_W'(64'd1 << (FB + 1));
	localparam logic [SUM_W-1:0]      FOUR    = SUM_W'(64'd1 << (FB + 2));

	logic [mandel_pkg::COORD_W-1:0] row_q;
	logic [mandel_pkg::COORD_W-1:0] col_q;
	logic signed [C_W-1:0]  cr_q;
	logic signed [C_W-1:0]  ci_q;
	logic signed [Z_W-1:0]  zr_q;
	logic signed [Z_W-1:0]  zi_q;
	logic [SQ_W-1:0]        sr_q;
	logic [SQ_W-1:0]        si_q;
	logic signed [PZ_W-1:0] pz_q;
	logic [mandel_pkg::ITER_W-1:0] k_q;

	logic [PROD_W-1:0]      cx;
	logic [PROD_W-1:0]      cy;
	logic signed [N_W-1:0]  nr;
	logic signed [N_W-1:0]  ni;
	logic signed [P_W-1:0]  prr;
	logic signed [P_W-1:0]  pii;
	logic signed [P_W-1:0]  prz;
	logic [SUM_W-1:0]       sq_sum;
	logic                   sum_esc;
	logic                   at_limit;
	logic [CNT_W-1:0]       pal_sum;

	assign cx = col_q * cfg.x_step;
	assign cy = row_q * cfg.y_step;

	// next iterate from the rounded squares of the previous one
	assign nr = N_W'(sr_q) - N_W'(si_q) + N_W'(cr_q);
	assign ni = N_W'(pz_q) + N_W'(ci_q);

	assign prr = zr_q * zr_q;
	assign pii = zi_q * zi_q;
	assign prz = zr_q * zi_q;

	assign sq_sum   = SUM_W'(sr_q) + SUM_W'(si_q);
	assign sum_esc  = sq_sum >= FOUR;
	assign at_limit = (k_q != '0) && (k_q >= cfg.iteration_limit);

	assign stat.stop    = sum_esc || at_limit;
	assign stat.mag_esc = !((nr < MAG_LIM) && (nr > -MAG_LIM) &&
		(ni < MAG_LIM) && (ni > -MAG_LIM));

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			row_q <= row;
			col_q <= column;
		end
		if (cmd.load) begin
			cr_q <= C_W'(cfg.view_left) + C_W'(cx);
			ci_q <= C_W'(cfg.view_top) - C_W'(cy);
			sr_q <= '0;
			si_q <= '0;
			pz_q <= '0;
			k_q  <= '0;
		end
		if (cmd.step) begin
			zr_q <= nr[Z_W-1:0];
			zi_q <= ni[Z_W-1:0];
			k_q  <= k_q + 1'b1;
		end
		// bit selects of the products give floor rounding
		if (cmd.square) begin
			sr_q <= prr[FB+SQ_W-1:FB];
			si_q <= pii[FB+SQ_W-1:FB];
			pz_q <= prz[FB-1+PZ_W-1:FB-1];
		end
	end

	// palette size is a power of two, so the modulo keeps the low bits
	assign pal_sum        = CNT_W'(k_q) + CNT_W'(cfg.palette_offset);
	assign res_in_set     = k_q == cfg.iteration_limit;
	assign res_palette    = res_in_set ? '0 : pal_sum[mandel_pkg::PAL_W-1:0];
	assign res_iterations = k_q;

endmodule

`default_nettype wire

// ===== design/mandelbrot_escape_time_pixel_core.sv =====
// Mandelbrot escape-time pixel core: one pixel per transaction in, one result out.
// Input channel: in_valid/in_stall with row and column of the pixel. The core takes
// a new transaction only while no pixel is being iterated.
// The point c is formed from view_left, view_top, x_step and y_step in signed
// Q4.28, then z = z*z + c is iterated from zero until |z|^2 >= 4 or the count
// reaches iteration_limit. Each iteration has an update step that adds and tests
// the iterate and a squaring step on three 30x30 multipliers.
// Output channel: out_valid/out_stall with in_set, palette_index and iterations.
// A result sits in an output register, so a new pixel can be accepted while it
// waits; a pixel that finishes while the previous result is still stalled holds
// until that one is taken.
// Configuration: apb-style port, register i at byte address 4*i, to be written
// by the user only while the core is idle; the block itself does not enforce it.
// Reset restores the default view and empties the core.

`default_nettype none

module mandelbrot_escape_time_pixel_core (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [mandel_pkg::PADDR_W-1:0]    paddr,
	input  wire logic [mandel_pkg::DATA_W-1:0]     pwdata,
	output logic [mandel_pkg::DATA_W-1:0]          prdata,
	output logic                                   pready,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [mandel_pkg::COORD_W-1:0]    row,
	input  wire logic [mandel_pkg::COORD_W-1:0]    column,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic                                   in_set,
	output logic [mandel_pkg::PAL_W-1:0]           palette_index,
	output logic [mandel_pkg::ITER_W-1:0]          iterations
);

	mandel_pkg::cfg_t     cfg;
	mandel_pkg::dp_cmd_t  cmd;
	mandel_pkg::dp_stat_t stat;

	logic                          emit;
	logic                          out_free;
	logic                          out_valid_q;
	logic                          in_set_q;
	logic [mandel_pkg::PAL_W-1:0]  palette_q;
	logic [mandel_pkg::ITER_W-1:0] iterations_q;
	logic                          res_in_set;
	logic [mandel_pkg::PAL_W-1:0]  res_palette;
	logic [mandel_pkg::ITER_W-1:0] res_iterations;

	mandel_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	mandel_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.out_free (out_free),
		.stat     (stat),
		.in_stall (in_stall),
		.emit     (emit),
		.cmd      (cmd)
	);

	mandel_dp u_dp (
		.clk            (clk),
		.cfg            (cfg),
		.cmd            (cmd),
		.row            (row),
		.column         (column),
		.stat           (stat),
		.res_in_set     (res_in_set),
		.res_palette    (res_palette),
		.res_iterations (res_iterations)
	);

	// output register frees up in the cycle its transaction completes
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			in_set_q     <= res_in_set;
			palette_q    <= res_palette;
			iterations_q <= res_iterations;
		end
	end

	assign out_valid     = out_valid_q;
	assign in_set        = in_set_q;
	assign palette_index = palette_q;
	assign iterations    = iterations_q;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("core took a second pixel right after a transaction");

	a_count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((iterations != '0) &&
		((iterations <= cfg.iteration_limit) || (iterations == 16'd1))))
		else $error("iteration count outside the configured limit");

	a_inside_palette: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && in_set) |-> (palette_index == '0))
		else $error("palette index set for a pixel inside the set");

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// self-checking testbench for the mandelbrot escape-time pixel core
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import mandel_pkg::*;

	localparam int CYCLE_LIMIT      = 2_000_000;
	localparam int SETTLE_CYCLES    = 8;
	localparam int RAND_PHASES      = 16;
	localparam int PIXELS_PER_PHASE = 50;
	localparam int HOLD_CYCLES      = 300;
	localparam longint ONE_Q        = longint'(1) << FRAC_BITS;
	localparam longint ESC_MAG      = 2 * ONE_Q;
	localparam longint ESC_SQ       = 4 * ONE_Q;

	typedef struct packed {
		logic              in_set;
		logic [PAL_W-1:0]  palette_index;
		logic [ITER_W-1:0] iterations;
	} escape_result_t;

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PADDR_W-1:0]  paddr;
	logic [DATA_W-1:0]   pwdata;
	logic [DATA_W-1:0]   prdata;
	logic                pready;
	logic                in_valid;
	logic                in_stall;
	logic [COORD_W-1:0]  row;
	logic [COORD_W-1:0]  column;
	logic                out_valid;
	logic                out_stall;
	logic                in_set;
	logic [PAL_W-1:0]    palette_index;
	logic [ITER_W-1:0]   iterations;

	cfg_t           view_cfg;
	escape_result_t expected_escapes[$];
	int             error_count;
	int             cycle_count;
	int             pixels_sent;
	int             pixels_in_set;
	int             views_loaded;
	int             rx_hold;
	bit             tx_gaps;
	bit             rx_gaps;

	mandelbrot_escape_time_pixel_core u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.row           (row),
		.column        (column),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.in_set        (in_set),
		.palette_index (palette_index),
		.iterations    (iterations)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("timeout after %0d cycles, %0d pixels still pending", cycle_count,
			expected_escapes.size());
		$display("CHECKS FAILED");
		$finish;
	end

	// floor(a*b / 2^shift), exact through a 128-bit product
	function automatic longint floor_product(longint a, longint b, int shift);
		logic signed [127:0] p;
		p = a;
		p = p * b;
		return longint'(p >>> shift);
	endfunction

	function automatic escape_result_t escape_result(logic [COORD_W-1:0] pix_row,
			logic [COORD_W-1:0] pix_col);
		longint         c_re;
		longint         c_im;
		longint         z_re;
		longint         z_im;
		longint         re_sq;
		longint         im_sq;
		longint         next_re;
		longint         next_im;
		int unsigned    count;
		bit             escaped;
		escape_result_t res;
		c_re = longint'($signed(view_cfg.view_left)) + longint'(pix_col) * longint'(view_cfg.x_step);
		c_im = longint'($signed(view_cfg.view_top)) - longint'(pix_row) * longint'(view_cfg.y_step);
		z_re = 0;
		z_im = 0;
		re_sq = 0;
		im_sq = 0;
		count = 0;
		escaped = 1'b0;
		do begin
			next_re = (re_sq - im_sq) + c_re;
			next_im = floor_product(z_re, z_im, FRAC_BITS - 1) + c_im;
			count++;
			// coarse magnitude test first keeps the squares in range
			if (next_re >= ESC_MAG || next_re <= -ESC_MAG ||
					next_im >= ESC_MAG || next_im <= -ESC_MAG) begin
				escaped = 1'b1;
			end else begin
				re_sq = floor_product(next_re, next_re, FRAC_BITS);
				im_sq = floor_product(next_im, next_im, FRAC_BITS);
				escaped = (re_sq + im_sq >= ESC_SQ);
			end
			z_re = next_re;
			z_im = next_im;
		end while (!escaped && count < view_cfg.iteration_limit);
		res.in_set = (count == view_cfg.iteration_limit);
		res.palette_index = res.in_set ? '0 :
			PAL_W'((count + view_cfg.palette_offset) % PALETTE_SIZE);
		res.iterations = ITER_W'(count);
		return res;
	endfunction

	function automatic logic [DATA_W-1:0] reg_value(reg_idx_t idx);
		case (idx)
			REG_VIEW_LEFT:       return view_cfg.view_left;
			REG_VIEW_TOP:        return view_cfg.view_top;
			REG_X_STEP:          return DATA_W'(view_cfg.x_step);
			REG_Y_STEP:          return DATA_W'(view_cfg.y_step);
			REG_ITERATION_LIMIT: return DATA_W'(view_cfg.iteration_limit);
			REG_PALETTE_OFFSET:  return DATA_W'(view_cfg.palette_offset);
			default:             return '0;
		endcase
	endfunction

	function automatic logic [COORD_W-1:0] pick_coord();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return '1;
			default: return COORD_W'($urandom);
		endcase
	endfunction

	// leaves the bus in its access phase so a following access can start at once
	task automatic apb_access(input bit wr, input logic [PADDR_W-1:0] addr,
			input logic [DATA_W-1:0] wdata, output logic [DATA_W-1:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		rdata = prdata;
		do @(posedge clk); while (!pready);
	endtask

	task automatic bus_idle();
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic load_view(input logic [DATA_W-1:0] left, input logic [DATA_W-1:0] top,
			input logic [STEP_W-1:0] x_inc, input logic [STEP_W-1:0] y_inc,
			input logic [ITER_W-1:0] limit, input logic [OFFS_W-1:0] offset);
		logic [DATA_W-1:0] value;
		logic [DATA_W-1:0] rd;
		reg_idx_t          idx;
		for (int i = REG_VIEW_LEFT; i <= REG_PALETTE_OFFSET; i++) begin
			idx = reg_idx_t'(i);
			case (idx)
				REG_VIEW_LEFT: begin
					value = left;
					view_cfg.view_left = left;
				end
				REG_VIEW_TOP: begin
					value = top;
					view_cfg.view_top = top;
				end
				REG_X_STEP: begin
					value = DATA_W'(x_inc);
					view_cfg.x_step = x_inc;
				end
				REG_Y_STEP: begin
					value = DATA_W'(y_inc);
					view_cfg.y_step = y_inc;
				end
				REG_ITERATION_LIMIT: begin
					value = DATA_W'(limit);
					view_cfg.iteration_limit = limit;
				end
				default: begin
					value = DATA_W'(offset);
					view_cfg.palette_offset = offset;
				end
			endcase
			apb_access(1'b1, {idx, 2'b00}, value, rd);
			apb_access(1'b0, {idx, 2'b00}, '0, rd);
			if (rd !== reg_value(idx)) begin
				$error("register %s: expected %h, got %h", idx.name(), reg_value(idx), rd);
				error_count++;
			end
		end
		bus_idle();
		views_loaded++;
	endtask

	task automatic send_pixel(input logic [COORD_W-1:0] pix_row, input logic [COORD_W-1:0] pix_col);
		if (tx_gaps && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		in_valid <= 1'b1;
		row <= pix_row;
		column <= pix_col;
		do @(posedge clk); while (in_stall);
		expected_escapes.push_back(escape_result(pix_row, pix_col));
		pixels_sent++;
	endtask

	// the core is idle once every accepted pixel has come back
	task automatic wait_all_results();
		in_valid <= 1'b0;
		while (expected_escapes.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	always @(posedge clk) begin : check_results
		escape_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_escapes.size() == 0) begin
				$error("result with no pixel pending: in_set %0d iterations %0d",
					in_set, iterations);
				error_count++;
			end else begin
				want = expected_escapes.pop_front();
				if (in_set !== want.in_set) begin
					$error("in_set: expected %0d, got %0d", want.in_set, in_set);
					error_count++;
				end
				if (palette_index !== want.palette_index) begin
					$error("palette_index: expected %0d, got %0d", want.palette_index,
						palette_index);
					error_count++;
				end
				if (iterations !== want.iterations) begin
					$error("iterations: expected %0d, got %0d", want.iterations, iterations);
					error_count++;
				end
				if (want.in_set)
					pixels_in_set++;
			end
		end
	end

	initial begin : receiver_stall
		int burst;
		burst = 0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold > 0) begin
				out_stall <= 1'b1;
				rx_hold--;
			end else if (burst > 0) begin
				out_stall <= 1'b1;
				burst--;
			end else if (rx_gaps && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				burst = $urandom_range(0, 7);
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	task automatic test_reset_defaults();
		logic [DATA_W-1:0] rd;
		reg_idx_t          idx;
		for (int i = REG_VIEW_LEFT; i <= REG_PALETTE_OFFSET; i++) begin
			idx = reg_idx_t'(i);
			apb_access(1'b0, {idx, 2'b00}, '0, rd);
			if (rd !== reg_value(idx)) begin
				$error("register %s after reset: expected %h, got %h", idx.name(),
					reg_value(idx), rd);
				error_count++;
			end
		end
		bus_idle();
		tx_gaps = 1'b1;
		rx_gaps = 1'b1;
		// default view: c = -2 + col/1024 + i(1 - row/1024)
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd1024, 12'd0);
		send_pixel(12'd1024, 12'd2048);
		send_pixel(12'd1024, 12'd1536);
		send_pixel(12'd4095, 12'd4095);
		wait_all_results();
	endtask

	task automatic test_register_extremes();
		load_view(32'h8000_0000, 32'h7FFF_FFFF, '1, '1, 16'd1, 8'd255);
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd0, 12'd4095);
		send_pixel(12'd4095, 12'd0);
		send_pixel(12'd4095, 12'd4095);
		wait_all_results();
		load_view(32'h7FFF_FFFF, 32'h8000_0000, '0, '0, 16'd65535, 8'd0);
		send_pixel(12'd4095, 12'd0);
		wait_all_results();
		// origin never escapes: runs the full limit
		load_view(32'h0, 32'h0, '0, '0, 16'd65535, 8'd0);
		send_pixel(12'd4095, 12'd4095);
		wait_all_results();
	endtask

	task automatic test_special_cases();
		// a zero limit still runs one pass and reports a palette index
		load_view(32'h0, 32'h0, '0, '0, 16'd0, 8'd200);
		send_pixel(pick_coord(), pick_coord());
		wait_all_results();
		// c = 1.0 escapes on the second pass, which here is the last one
		load_view(32'h1000_0000, 32'h0, '0, '0, 16'd2, 8'd7);
		send_pixel(12'd0, 12'd0);
		wait_all_results();
		load_view(32'h1000_0000, 32'h0, '0, '0, 16'd3, 8'd255);
		send_pixel(12'd0, 12'd0);
		wait_all_results();
	endtask

	task automatic test_unused_addresses();
		logic [DATA_W-1:0] rd;
		for (int i = REG_PALETTE_OFFSET + 1; i < (1 << (PADDR_W - 2)); i++)
			apb_access(1'b1, PADDR_W'(i * 4), $urandom, rd);
		bus_idle();
		send_pixel(pick_coord(), pick_coord());
		send_pixel(pick_coord(), pick_coord());
		wait_all_results();
	endtask

	task automatic test_random_views();
		logic [DATA_W-1:0]  left;
		logic [DATA_W-1:0]  top;
		logic [STEP_W-1:0]  x_inc;
		logic [STEP_W-1:0]  y_inc;
		logic [ITER_W-1:0]  limit;
		int                 pick;
		for (int phase = 0; phase < RAND_PHASES; phase++) begin
			tx_gaps = ($urandom_range(0, 3) != 0);
			rx_gaps = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 5) == 0) begin
				// arbitrary window, mostly far outside the set
				left = $urandom;
				top = $urandom;
				x_inc = STEP_W'($urandom);
				y_inc = STEP_W'($urandom);
				limit = ITER_W'($urandom_range(1, 32));
			end else begin
				// window over the interesting region: real -2.5..0.5, imag -1.25..1.25
				left = DATA_W'($urandom_range(0, 805306368)) - DATA_W'(671088640);
				top = DATA_W'($urandom_range(0, 671088640)) - DATA_W'(335544320);
				x_inc = STEP_W'($urandom_range(1, 262144));
				y_inc = STEP_W'($urandom_range(1, 262144));
				pick = $urandom_range(0, 9);
				if (pick < 6)
					limit = ITER_W'($urandom_range(1, 32));
				else if (pick < 9)
					limit = ITER_W'($urandom_range(33, 128));
				else
					limit = ITER_W'($urandom_range(200, 300));
			end
			load_view(left, top, x_inc, y_inc, limit, OFFS_W'($urandom_range(0, 255)));
			repeat (PIXELS_PER_PHASE) send_pixel(pick_coord(), pick_coord());
			wait_all_results();
		end
	endtask

	task automatic test_full_pipeline_pressure();
		tx_gaps = 1'b0;
		rx_gaps = 1'b0;
		load_view(32'hE000_0000, 32'h1000_0000, 31'd131072, 31'd131072, 16'd8,
			OFFS_W'($urandom_range(0, 255)));
		// receiver holds off long enough for the input side to back up
		rx_hold = HOLD_CYCLES;
		repeat (10) send_pixel(pick_coord(), pick_coord());
		wait_all_results();
	endtask

	task automatic test_steady_stream();
		tx_gaps = 1'b0;
		rx_gaps = 1'b0;
		load_view(32'hE000_0000, 32'h1000_0000, 31'd262144, 31'd262144, 16'd64, 8'd5);
		repeat (40) send_pixel(pick_coord(), pick_coord());
		wait_all_results();
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		row = '0;
		column = '0;
		tx_gaps = 1'b0;
		rx_gaps = 1'b0;
		rx_hold = 0;
		view_cfg.view_left = 32'hE000_0000;
		view_cfg.view_top = 32'h1000_0000;
		view_cfg.x_step = 31'd262144;
		view_cfg.y_step = 31'd262144;
		view_cfg.iteration_limit = 16'd256;
		view_cfg.palette_offset = 8'd0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_register_extremes();
		test_special_cases();
		test_unused_addresses();
		test_random_views();
		test_full_pipeline_pressure();
		test_steady_stream();
		if (expected_escapes.size() != 0) begin
			$error("%0d pixels never returned a result", expected_escapes.size());
			error_count++;
		end
		$display("%0d pixels checked over %0d view settings, %0d of them inside the set",
			pixels_sent, views_loaded, pixels_in_set);
		$display("%0d mismatches in %0d cycles", error_count, cycle_count);
		if (error_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
